FILE: hdl/lbp3_pkg.sv
// Shared types and constants for the 3x3 local binary pattern core.
// No dependencies; imported by the core and its checker.
`timescale 1ns / 1ps

package lbp3_pkg;

  localparam int LbpCodeW      = 8;
  localparam int CfgIdxW       = 1;
  localparam int CfgDataW      = 16;
  localparam int FrameWidthW   = 11;
  localparam int FrameHeightW  = 16;

  localparam logic [FrameWidthW-1:0]  FrameWidthReset  = 11'd640;
  localparam logic [FrameHeightW-1:0] FrameHeightReset = 16'd480;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

endpackage

FILE: hdl/lbp3_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lbp3_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/local_binary_pattern_3x3_core.sv
// 3x3 local binary pattern over a raster pixel stream; uses lbp3_pkg, lbp3_ram.
// An accepted pixel is registered in stage 1; its code enters the output register when
// stage 1 advances. Throughput: one pixel per cycle while in_stall_o is low; the line
// RAM is read on acceptance, written as stage 1 advances; one read, one write per pixel.
// Reset clears counters, window and pipeline valids and sets 640x480; the line
// RAM is not cleared (the first two rows of a frame rewrite it before any code uses it).
`timescale 1ns / 1ps

module local_binary_pattern_3x3_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lbp3_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lbp3_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [PIXEL_BITS-1:0]         pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lbp3_pkg::LbpCodeW-1:0] lbp_code_o,
  output logic                          frame_last_o
);

  import lbp3_pkg::*;

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int WCmpW = ((ColW > FrameWidthW) ? ColW : FrameWidthW) + 1;
  localparam int HCmpW = FrameHeightW + 1;

  typedef struct packed {
    logic [ColW-1:0]       addr;
    logic [PIXEL_BITS-1:0] cur;
    logic                  emit;
    logic                  last;
  } s1_t;

  // configuration
  logic [FrameWidthW-1:0]  frame_width_q, frame_width_d;
  logic [FrameHeightW-1:0] frame_height_q, frame_height_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  frame_width_d  = cfg_data_i[FrameWidthW-1:0];
        REG_FRAME_HEIGHT: frame_height_d = cfg_data_i[FrameHeightW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthReset;
      frame_height_q <= FrameHeightReset;
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
    end
  end

  // stage 0: counters and line RAM read
  logic [ColW-1:0]         col_q, col_d;
  logic [FrameHeightW-1:0] row_q, row_d;
  logic [WCmpW-1:0]        fw_ext, eff_w;
  logic [HCmpW-1:0]        fh_ext, eff_h;
  logic                    row_end, frame_end, emit;
  logic                    in_accept;

  always_comb begin
    fw_ext = WCmpW'(frame_width_q);
    if (fw_ext < WCmpW'(3)) begin
      eff_w = WCmpW'(3);
    end else if (fw_ext > WCmpW'(MAX_WIDTH)) begin
      eff_w = WCmpW'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext;
    end
    fh_ext = HCmpW'(frame_height_q);
    eff_h  = (fh_ext < HCmpW'(3)) ? HCmpW'(3) : fh_ext;

    row_end   = (WCmpW'(col_q) + WCmpW'(1)) >= eff_w;
    frame_end = row_end && ((HCmpW'(row_q) + HCmpW'(1)) >= eff_h);
    emit      = (row_q >= FrameHeightW'(2)) && (WCmpW'(col_q) >= WCmpW'(2));

    col_d = col_q;
    row_d = row_q;
    if (in_accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + FrameHeightW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1: read data arrives, code computed, RAM written back
  logic                      s1_valid_q;
  s1_t                       s1_q;
  logic                      s1_adv;
  logic                      out_free;
  logic [2*PIXEL_BITS-1:0]   ram_rdata;
  logic [PIXEL_BITS-1:0]     top, mid;
  logic [PIXEL_BITS-1:0]     win_q [6];
  logic [LbpCodeW-1:0]       code;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!s1_q.emit || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Back-to-back pixels always sit at different columns (width is at least 3),
  // so the write-back never hits the entry being read in the same cycle.
  lbp3_ram #(
    .Width (2 * PIXEL_BITS),
    .Depth (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_q.addr),
    .wdata_i ({mid, s1_q.cur}),
    .re_i    (in_accept),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  assign top = ram_rdata[2*PIXEL_BITS-1:PIXEL_BITS];
  assign mid = ram_rdata[PIXEL_BITS-1:0];

  // window: [0..2] two columns back top/mid/bot, [3..5] one column back
  always_comb begin
    code[7] = win_q[0] >= win_q[4];
    code[6] = win_q[3] >= win_q[4];
    code[5] = top      >= win_q[4];
    code[4] = mid      >= win_q[4];
    code[3] = s1_q.cur >= win_q[4];
    code[2] = win_q[5] >= win_q[4];
    code[1] = win_q[2] >= win_q[4];
    code[0] = win_q[1] >= win_q[4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= top;
        win_q[4] <= mid;
        win_q[5] <= s1_q.cur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.addr <= col_q;
      s1_q.cur  <= pixel_i;
      s1_q.emit <= emit;
      s1_q.last <= frame_end;
    end
  end

  // output register
  logic                out_valid_q;
  logic [LbpCodeW-1:0] code_q;
  logic                last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.emit) begin
      code_q <= code;
      last_q <= s1_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign lbp_code_o   = code_q;
  assign frame_last_o = last_q;

endmodule

FILE: hdl/lbp3_checker.sv
// Port-level checks for local_binary_pattern_3x3_core, bound to the top level.
// Uses lbp3_pkg for field widths.
`timescale 1ns / 1ps

module lbp3_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [lbp3_pkg::LbpCodeW-1:0] lbp_code_o,
  input logic                          frame_last_o
);

  import lbp3_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(lbp_code_o) && $stable(frame_last_o))
    else $error("stalled output transaction changed");

  // an empty output register never backs up the input
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output register empty");

  // a result after an idle output comes from an accepted pixel, with no stall in between
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("output transaction without a matching input transaction");

endmodule

bind local_binary_pattern_3x3_core lbp3_checker u_lbp3_checker (.*);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for local_binary_pattern_3x3_core: streams pixel frames,
// predicts each LBP code and frame_last flag, and compares them in order.
// Depends on lbp3_pkg and the core.

module tb_top;
  import lbp3_pkg::*;

  localparam int LineDepth     = 1024;
  localparam int IdlePct       = 31;
  localparam int SettleCycles  = 4;
  localparam int HoldOffCycles = 300;
  localparam int QuietLimit    = 2000;
  localparam int RandomPixels  = 1620;
  localparam int MaxReports    = 10;

  typedef struct packed {
    logic [LbpCodeW-1:0] code;
    logic                last;
  } lbp_result_t;

  typedef enum int {PIX_NOISE, PIX_FLAT, PIX_EXTREME} pixel_style_e;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                cfg_valid = 1'b0;
  cfg_reg_e            cfg_index = REG_FRAME_WIDTH;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                cfg_ready;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [7:0]          pixel     = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [LbpCodeW-1:0] lbp_code;
  logic                frame_last;

  // Shadow of the core: registers, line rows, window and raster position
  logic [FrameWidthW-1:0]  width_reg  = FrameWidthReset;
  logic [FrameHeightW-1:0] height_reg = FrameHeightReset;
  logic [7:0]              line_top [LineDepth] = '{default: '0};
  logic [7:0]              line_mid [LineDepth] = '{default: '0};
  logic [7:0]              win [6] = '{default: '0};
  int unsigned             col_cnt = 0;
  int unsigned             row_cnt = 0;

  logic [7:0]    pixel_q[$];
  lbp_result_t   pending_codes[$];
  int unsigned   pixels_sent     = 0;
  int unsigned   pixels_accepted = 0;
  int unsigned   error_cnt       = 0;
  bit            calm            = 1'b0;
  bit            pressure_req    = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  local_binary_pattern_3x3_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .pixel_i      (pixel),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .lbp_code_o   (lbp_code),
    .frame_last_o (frame_last)
  );

  function automatic int unsigned eff_width();
    int unsigned w = width_reg;
    if (w < 3) w = 3;
    if (w > LineDepth) w = LineDepth;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h = height_reg;
    if (h < 3) h = 3;
    return h;
  endfunction

  // Pixels still owed before the counters wrap to the next frame
  function automatic int unsigned pixels_to_frame_end();
    int unsigned w = eff_width();
    int unsigned h = eff_height();
    int unsigned in_row;
    in_row = (col_cnt >= w - 1) ? 1 : w - col_cnt;
    return (row_cnt >= h - 1) ? in_row : in_row + (h - 1 - row_cnt) * w;
  endfunction

  task automatic predict_lbp(input logic [7:0] cur);
    int unsigned w;
    int unsigned h;
    int unsigned idx;
    logic [7:0]  top;
    logic [7:0]  mid;
    logic [7:0]  c;
    bit          row_end;
    bit          frame_end;
    lbp_result_t r;
    w         = eff_width();
    h         = eff_height();
    idx       = (col_cnt < LineDepth) ? col_cnt : LineDepth - 1;
    top       = line_top[idx];
    mid       = line_mid[idx];
    row_end   = (col_cnt >= w - 1);
    frame_end = row_end && (row_cnt >= h - 1);
    if (row_cnt >= 2 && col_cnt >= 2) begin
      c      = win[4];
      // clockwise from top-left (bit 7) to left (bit 0)
      r.code = {win[0] >= c, win[3] >= c, top >= c, mid >= c,
                cur >= c, win[5] >= c, win[2] >= c, win[1] >= c};
      r.last = frame_end;
      pending_codes.push_back(r);
    end
    line_top[idx] = mid;
    line_mid[idx] = cur;
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = cur;
    if (row_end) begin
      col_cnt = 0;
      row_cnt = frame_end ? 0 : (row_cnt + 1) & 16'hFFFF;
    end else begin
      col_cnt = (col_cnt + 1) & 14'h3FFF;
    end
  endtask

  task automatic log_error(input string msg);
    error_cnt++;
    if (error_cnt <= MaxReports) $display("%0t: %s", $realtime, msg);
  endtask

  // Driver: offer queued pixels, hold the payload while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_lbp(pixel);
        pixels_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pixel_q.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
          in_valid <= 1'b1;
          pixel    <= pixel_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction against the oldest prediction
  int unsigned holdoff_left  = 0;
  bit          pressure_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    lbp_result_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_codes.size() == 0) begin
          log_error($sformatf("unexpected result: code=%02h last=%0b",
                              lbp_code, frame_last));
        end else begin
          want = pending_codes.pop_front();
          if (lbp_code !== want.code || frame_last !== want.last) begin
            log_error($sformatf("result mismatch: expected code=%02h last=%0b, got code=%02h last=%0b",
                                want.code, want.last, lbp_code, frame_last));
          end
        end
      end
      // Back-pressure once long enough for the core to fill and stall its input
      if (pressure_req && !pressure_done && out_valid) begin
        pressure_done = 1'b1;
        holdoff_left  = HoldOffCycles;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IdlePct);
      end
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no transaction in %0d cycles", QuietLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_one(input logic [7:0] v);
    pixel_q.push_back(v);
    pixels_sent++;
  endtask

  task automatic push_pixels(input int unsigned n, input pixel_style_e style);
    int base;
    int v;
    base = $urandom_range(255);
    repeat (n) begin
      case (style)
        PIX_NOISE: v = $urandom_range(255);
        PIX_FLAT:  v = base + int'($urandom_range(2)) - 1;
        default:   v = $urandom_range(1) ? 255 : 0;
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      push_one(8'(v));
    end
  endtask

  // Wait until every pixel is taken and every code is out, then let the pipe settle
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pixels_accepted != pixels_sent || pending_codes.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = data[FrameWidthW-1:0];
    else height_reg = data;
  endtask

  initial begin : stimulus
    // 3x3 window around 128 with equal, smaller, larger and extreme neighbors
    logic [7:0]   bit_map [9]   = '{8'd128, 8'd0,   8'd255,
                                    8'd127, 8'd128, 8'd129,
                                    8'd255, 8'd127, 8'd128};
    logic [7:0]   tall_rows [12] = '{8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 8'd77,
                                     8'd77, 8'd77, 8'd77, 8'd0,  8'd255, 8'd0};
    logic [7:0]   tail_row [3]  = '{8'd255, 8'd0, 8'd255};
    int unsigned  random_pixels;
    int unsigned  full;
    int unsigned  part;
    int unsigned  rest;
    int unsigned  wreg;
    bit           over_range;
    bit           reconfig_due;
    bit           big_done;
    pixel_style_e style;

    random_pixels = 0;
    reconfig_due  = 1'b1;
    big_done      = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Width 0 and height 2 clamp to 3x3; upper data bits are not part of the width
    write_reg(REG_FRAME_WIDTH, 16'hF800);
    write_reg(REG_FRAME_HEIGHT, 16'd2);
    foreach (bit_map[k]) push_one(bit_map[k]);
    wait_drained();

    // Tallest frame, then cut its height while mid-frame
    write_reg(REG_FRAME_WIDTH, 16'd3);
    write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
    foreach (tall_rows[k]) push_one(tall_rows[k]);
    wait_drained();
    write_reg(REG_FRAME_HEIGHT, 16'd0);
    foreach (tail_row[k]) push_one(tail_row[k]);

    while (random_pixels < RandomPixels) begin
      if (!big_done && random_pixels >= RandomPixels / 2) begin
        // Wide frame, no idling, one long output hold-off
        wait_drained();
        write_reg(REG_FRAME_WIDTH, 16'd64);
        write_reg(REG_FRAME_HEIGHT, 16'd6);
        calm         = 1'b1;
        pressure_req = 1'b1;
        push_pixels(64 * 6, PIX_NOISE);
        wait_drained();
        calm         = 1'b0;
        big_done     = 1'b1;
        reconfig_due = 1'b1;
        random_pixels += 64 * 6;
      end

      over_range = ($urandom_range(7) == 0);
      if (reconfig_due || $urandom_range(1)) begin
        wait_drained();
        wreg = over_range ? $urandom_range(2047, 1025) : $urandom_range(24);
        write_reg(REG_FRAME_WIDTH, {5'($urandom), 11'(wreg)});
        write_reg(REG_FRAME_HEIGHT, 16'($urandom_range(9)));
        reconfig_due = 1'b0;
      end else begin
        over_range = 1'b0;
      end

      style = pixel_style_e'($urandom_range(2));
      full  = eff_width() * eff_height();
      if (over_range || $urandom_range(4) == 0) begin
        // Break the frame: stop partway, shrink the width or move the height
        part = over_range ? $urandom_range(60, 20) : $urandom_range(full - 1, 1);
        push_pixels(part, style);
        wait_drained();
        if (over_range || $urandom_range(1)) begin
          write_reg(REG_FRAME_WIDTH,
                    16'(over_range ? $urandom_range(12) : $urandom_range(eff_width())));
        end else begin
          write_reg(REG_FRAME_HEIGHT, 16'($urandom_range(12)));
        end
        rest = pixels_to_frame_end();
        push_pixels(rest, style);
        random_pixels += part + rest;
      end else begin
        push_pixels(full, style);
        random_pixels += full;
      end
    end

    wait_drained();
    repeat (2 * SettleCycles) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
